// ----- hw/rtl/itrd_pkg.sv -----
// ----------------------------------------------------------------------------
// itrd_pkg
// Shared constants, types and helpers for the integer to radix digits block.
// ----------------------------------------------------------------------------
`default_nettype none

package itrd_pkg;

    localparam int VALUE_BITS_DEFAULT = 32;
    localparam int INPUT_WIDTH        = 32;
    localparam int RADIX_WIDTH        = 5;
    localparam int DIGIT_WIDTH        = 4;
    localparam int CHAR_WIDTH         = 7;
    localparam int STORE_DEPTH        = 32;
    localparam int INDEX_WIDTH        = 5;
    localparam int COUNT_WIDTH        = 6;
    localparam int DIV_BITS           = 8;
    localparam int QUEUE_DEPTH        = 2;

    localparam logic [RADIX_WIDTH-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_WIDTH-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_WIDTH-1:0] RADIX_MAX   = 5'd16;

    localparam logic [CHAR_WIDTH-1:0]  ASCII_ZERO        = 7'd48;
    localparam logic [CHAR_WIDTH-1:0]  ASCII_LETTER_BASE = 7'd55;
    localparam logic [DIGIT_WIDTH-1:0] DECIMAL_LIMIT     = 4'd10;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_READ,
        BK_EMIT
    } back_state_t;

    function automatic logic [CHAR_WIDTH-1:0] to_ascii(input logic [DIGIT_WIDTH-1:0] d);
        logic [CHAR_WIDTH-1:0] base;
        base = (d < DECIMAL_LIMIT) ? ASCII_ZERO : ASCII_LETTER_BASE;
        return base + CHAR_WIDTH'(d);
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/itrd_front.sv -----
// ----------------------------------------------------------------------------
// itrd_front
// Holds the radix register, accepts values, trims them to the value width
// and pairs each with its saturated radix for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module itrd_front #(
    parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                radix_we,
    input  wire logic [itrd_pkg::RADIX_WIDTH-1:0]    radix,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [itrd_pkg::INPUT_WIDTH-1:0]    value,
    output logic                                     push_valid,
    input  wire logic                                push_ready,
    output logic [((((VALUE_BITS < itrd_pkg::INPUT_WIDTH) ? VALUE_BITS :
                     itrd_pkg::INPUT_WIDTH) + itrd_pkg::DIV_BITS - 1) /
                   itrd_pkg::DIV_BITS) * itrd_pkg::DIV_BITS - 1:0] push_value,
    output logic [itrd_pkg::RADIX_WIDTH-1:0]         push_radix
);

    localparam int QW = (VALUE_BITS < itrd_pkg::INPUT_WIDTH) ? VALUE_BITS
                                                             : itrd_pkg::INPUT_WIDTH;
    localparam int CH = (QW + itrd_pkg::DIV_BITS - 1) / itrd_pkg::DIV_BITS;
    localparam int QP = CH * itrd_pkg::DIV_BITS;

    logic [itrd_pkg::RADIX_WIDTH-1:0] radix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= itrd_pkg::RADIX_RESET;
        end
        else if (radix_we)
        begin
            radix_reg <= radix;
        end
    end

    always_comb
    begin
        if (radix_reg < itrd_pkg::RADIX_MIN)
        begin
            push_radix = itrd_pkg::RADIX_MIN;
        end
        else if (radix_reg > itrd_pkg::RADIX_MAX)
        begin
            push_radix = itrd_pkg::RADIX_MAX;
        end
        else
        begin
            push_radix = radix_reg;
        end
    end

    assign push_value = QP'(value[QW-1:0]);
    assign push_valid = in_valid;
    assign in_ready   = push_ready;

endmodule

`default_nettype wire

// ----- hw/rtl/itrd_queue.sv -----
// ----------------------------------------------------------------------------
// itrd_queue
// Short register queue between the front and the digit engine.
// ----------------------------------------------------------------------------
`default_nettype none

module itrd_queue #(
    parameter int WIDTH = itrd_pkg::INPUT_WIDTH + itrd_pkg::RADIX_WIDTH,
    parameter int DEPTH = itrd_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    fill_reg;
    logic             push;
    logic             pop;

    assign push_ready = (fill_reg != CW'(DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/itrd_back.sv -----
// ----------------------------------------------------------------------------
// itrd_back
// Digit engine: repeated division by the radix, eight dividend bits per
// cycle, remainders into the digit store, then emission most significant
// first through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module itrd_back #(
    parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                q_valid,
    output logic                                     q_ready,
    input  wire logic [((((VALUE_BITS < itrd_pkg::INPUT_WIDTH) ? VALUE_BITS :
                          itrd_pkg::INPUT_WIDTH) + itrd_pkg::DIV_BITS - 1) /
                        itrd_pkg::DIV_BITS) * itrd_pkg::DIV_BITS - 1:0] q_value,
    input  wire logic [itrd_pkg::RADIX_WIDTH-1:0]    q_radix,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [itrd_pkg::CHAR_WIDTH-1:0]          digit_char,
    output logic                                     last
);

    localparam int QW = (VALUE_BITS < itrd_pkg::INPUT_WIDTH) ? VALUE_BITS
                                                             : itrd_pkg::INPUT_WIDTH;
    localparam int CH = (QW + itrd_pkg::DIV_BITS - 1) / itrd_pkg::DIV_BITS;
    localparam int QP = CH * itrd_pkg::DIV_BITS;
    localparam int CW = (CH > 1) ? $clog2(CH) : 1;
    localparam int DB = itrd_pkg::DIV_BITS;

    itrd_pkg::back_state_t state_reg;
    itrd_pkg::back_state_t state_next;

    logic [QP-1:0]                        dvd_reg;
    logic [QP-1:0]                        dvd_next;
    logic [itrd_pkg::DIGIT_WIDTH-1:0]     rem_reg;
    logic [itrd_pkg::DIGIT_WIDTH-1:0]     rem_next;
    logic [itrd_pkg::RADIX_WIDTH-1:0]     radix_reg;
    logic [CW-1:0]                        chunk_reg;
    logic [itrd_pkg::COUNT_WIDTH-1:0]     count_reg;
    logic [itrd_pkg::INDEX_WIDTH-1:0]     ptr_reg;
    logic [itrd_pkg::DIGIT_WIDTH-1:0]     rd_data_reg;
    logic [itrd_pkg::DIGIT_WIDTH-1:0]     store [itrd_pkg::STORE_DEPTH];
    logic                                 out_valid_reg;
    logic [itrd_pkg::CHAR_WIDTH-1:0]      digit_char_reg;
    logic                                 last_reg;

    logic [DB-1:0]                        qbits;
    logic [itrd_pkg::RADIX_WIDTH-1:0]     trial;
    logic [itrd_pkg::DIGIT_WIDTH-1:0]     part;

    logic chunk_last;
    logic count_full;
    logic quot_zero;
    logic out_free;
    logic q_pop;
    logic div_step;
    logic digit_we;
    logic rd_en;
    logic emit_load;

    // restoring long division over one byte of the dividend
    always_comb
    begin
        part  = rem_reg;
        trial = '0;
        qbits = '0;
        for (int i = 0; i < DB; i++)
        begin
            trial = {part, dvd_reg[QP-1-i]};
            if (trial >= radix_reg)
            begin
                trial          = trial - radix_reg;
                qbits[DB-1-i] = 1'b1;
            end
            part = trial[itrd_pkg::DIGIT_WIDTH-1:0];
        end
        rem_next = part;
    end

    assign dvd_next   = QP'({dvd_reg, qbits});
    assign chunk_last = (chunk_reg == CW'(CH - 1));
    assign count_full = (count_reg == itrd_pkg::COUNT_WIDTH'(itrd_pkg::STORE_DEPTH - 1));
    assign quot_zero  = (dvd_next == '0);
    assign out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            itrd_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = itrd_pkg::BK_DIV;
                end
            end
            itrd_pkg::BK_DIV:
            begin
                if (chunk_last && (quot_zero || count_full))
                begin
                    state_next = itrd_pkg::BK_READ;
                end
            end
            itrd_pkg::BK_READ:
            begin
                state_next = itrd_pkg::BK_EMIT;
            end
            itrd_pkg::BK_EMIT:
            begin
                if (out_free)
                begin
                    state_next = (ptr_reg == '0) ? itrd_pkg::BK_IDLE : itrd_pkg::BK_READ;
                end
            end
            default:
            begin
                state_next = itrd_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_ready   = (state_reg == itrd_pkg::BK_IDLE);
        div_step  = (state_reg == itrd_pkg::BK_DIV);
        digit_we  = (state_reg == itrd_pkg::BK_DIV) && chunk_last;
        rd_en     = (state_reg == itrd_pkg::BK_READ);
        emit_load = (state_reg == itrd_pkg::BK_EMIT) && out_free;
    end

    assign q_pop = q_valid && q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= itrd_pkg::BK_IDLE;
            chunk_reg     <= '0;
            count_reg     <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop)
            begin
                chunk_reg <= '0;
                count_reg <= '0;
            end
            else if (div_step)
            begin
                chunk_reg <= chunk_last ? '0 : chunk_reg + 1'b1;
                if (chunk_last)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (digit_we)
            begin
                ptr_reg <= count_reg[itrd_pkg::INDEX_WIDTH-1:0];
            end
            else if (emit_load && ptr_reg != '0)
            begin
                ptr_reg <= ptr_reg - 1'b1;
            end
            if (emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            dvd_reg   <= q_value;
            radix_reg <= q_radix;
            rem_reg   <= '0;
        end
        else if (div_step)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= chunk_last ? '0 : rem_next;
        end
        if (emit_load)
        begin
            digit_char_reg <= itrd_pkg::to_ascii(rd_data_reg);
            last_reg       <= (ptr_reg == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (digit_we)
        begin
            store[count_reg[itrd_pkg::INDEX_WIDTH-1:0]] <= rem_next;
        end
        if (rd_en)
        begin
            rd_data_reg <= store[ptr_reg];
        end
    end

    assign out_valid  = out_valid_reg;
    assign digit_char = digit_char_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/integer_to_radix_digits.sv -----
// ----------------------------------------------------------------------------
// integer_to_radix_digits
// Converts an unsigned value to ASCII digits in a base from 2 to 16.
// ----------------------------------------------------------------------------
// Each value transfer yields one character per digit, most significant first,
// '0'-'9' then 'A'-'F', with last set on the final digit; zero gives a single
// '0'. The radix register (reset 10) saturates to 2..16 and is sampled when a
// value enters; write it only while the block is idle. In the digit engine the
// divider retires eight bits of the used value width per cycle, and every digit
// is then read back from the digit store and loaded into the output register. A
// two-entry queue lets new values enter while a conversion runs.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_radix_digits #(
    parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                radix_we,
    input  wire logic [itrd_pkg::RADIX_WIDTH-1:0]    radix,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [itrd_pkg::INPUT_WIDTH-1:0]    value,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [itrd_pkg::CHAR_WIDTH-1:0]          digit_char,
    output logic                                     last
);

    localparam int QW = (VALUE_BITS < itrd_pkg::INPUT_WIDTH) ? VALUE_BITS
                                                             : itrd_pkg::INPUT_WIDTH;
    localparam int CH = (QW + itrd_pkg::DIV_BITS - 1) / itrd_pkg::DIV_BITS;
    localparam int QP = CH * itrd_pkg::DIV_BITS;
    localparam int EW = QP + itrd_pkg::RADIX_WIDTH;

    logic                             push_valid;
    logic                             push_ready;
    logic [QP-1:0]                    push_value;
    logic [itrd_pkg::RADIX_WIDTH-1:0] push_radix;
    logic                             q_valid;
    logic                             q_ready;
    logic [EW-1:0]                    q_data;

    itrd_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .radix_we   (radix_we),
        .radix      (radix),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_value (push_value),
        .push_radix (push_radix)
    );

    itrd_queue #(
        .WIDTH (EW),
        .DEPTH (itrd_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_value, push_radix}),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    itrd_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_value    (q_data[EW-1:itrd_pkg::RADIX_WIDTH]),
        .q_radix    (q_data[itrd_pkg::RADIX_WIDTH-1:0]),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .digit_char (digit_char),
        .last       (last)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/itrd_checker.sv -----
// ----------------------------------------------------------------------------
// itrd_checker
// Port-level checks for integer_to_radix_digits, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module itrd_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                in_valid,
    input wire logic                                in_ready,
    input wire logic [itrd_pkg::INPUT_WIDTH-1:0]    value,
    input wire logic                                out_valid,
    input wire logic                                out_ready,
    input wire logic [itrd_pkg::CHAR_WIDTH-1:0]     digit_char,
    input wire logic                                last
);

    // waiting value transfer keeps its payload
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(value))
        else $error("input changed while waiting");

    // stalled transfer holds its character and mark
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(digit_char) && $stable(last))
        else $error("output changed while stalled");

    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (digit_char >= 7'd48 && digit_char <= 7'd57) ||
                      (digit_char >= 7'd65 && digit_char <= 7'd70))
        else $error("digit character out of range");

    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("output valid out of reset");

endmodule

bind integer_to_radix_digits itrd_checker u_checker (.*);

`default_nettype wire

// ----- dv/itrd_digit_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrd_digit_checker
// Watches the value and digit channels, predicts the digit stream, compares.
// ----------------------------------------------------------------------------
// Tracks the radix register from the write port. Every value transfer is
// divided down here into its expected characters. Every digit transfer is
// checked against the oldest one, character and last flag alike.
// ----------------------------------------------------------------------------

module itrd_digit_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               radix_we,
    input  logic [itrd_pkg::RADIX_WIDTH-1:0]   radix,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic [itrd_pkg::INPUT_WIDTH-1:0]   value,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic [itrd_pkg::CHAR_WIDTH-1:0]    digit_char,
    input  logic                               last,
    output int                                 mismatches,
    output int                                 pending,
    output int                                 digits_checked
);
    import itrd_pkg::*;

    logic [RADIX_WIDTH-1:0] radix_q;
    logic [CHAR_WIDTH-1:0]  exp_char[$];
    logic                   exp_last[$];
    int                     fail_cnt;
    int                     seen_cnt;

    function automatic void queue_digits(input logic [INPUT_WIDTH-1:0] v,
                                         input logic [RADIX_WIDTH-1:0] rsel);
        logic [INPUT_WIDTH-1:0] q;
        logic [RADIX_WIDTH-1:0] base;
        logic [DIGIT_WIDTH-1:0] rem[STORE_DEPTH];
        int                     n;
        base = (rsel < RADIX_MIN) ? RADIX_MIN : ((rsel > RADIX_MAX) ? RADIX_MAX : rsel);
        q = v;
        n = 0;
        if (q == '0)
        begin
            rem[0] = '0;
            n = 1;
        end
        while (q != '0)
        begin
            rem[n] = DIGIT_WIDTH'(q % base);
            q = q / base;
            n++;
        end
        for (int k = n - 1; k >= 0; k--)
        begin
            if (rem[k] < DECIMAL_LIMIT)
                exp_char.push_back(ASCII_ZERO + CHAR_WIDTH'(rem[k]));
            else
                exp_char.push_back(ASCII_LETTER_BASE + CHAR_WIDTH'(rem[k]));
            exp_last.push_back(k == 0);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_q <= RADIX_RESET;
            exp_char.delete();
            exp_last.delete();
            fail_cnt = 0;
            seen_cnt = 0;
            mismatches <= 0;
            pending <= 0;
            digits_checked <= 0;
        end
        else
        begin
            if (radix_we)
                radix_q <= radix;
            // pop before push: a result never belongs to a value entering now
            if (out_valid && out_ready)
            begin
                if (exp_char.size() == 0)
                begin
                    if (fail_cnt < 10)
                        $display("[%0t] unexpected digit transfer: char=%0d last=%0b",
                                 $realtime, digit_char, last);
                    fail_cnt++;
                end
                else
                begin
                    if (digit_char !== exp_char[0] || last !== exp_last[0])
                    begin
                        if (fail_cnt < 10)
                            $display("[%0t] digit mismatch: exp char=%0d last=%0b, got char=%0d last=%0b",
                                     $realtime, exp_char[0], exp_last[0], digit_char, last);
                        fail_cnt++;
                    end
                    void'(exp_char.pop_front());
                    void'(exp_last.pop_front());
                    seen_cnt++;
                end
            end
            if (in_valid && in_ready)
                queue_digits(value, radix_q);
            mismatches <= fail_cnt;
            digits_checked <= seen_cnt;
            pending <= exp_char.size();
        end
    end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the integer to radix digits converter.
// ----------------------------------------------------------------------------
// Directed values first (zero, one, all ones, top bit, longest digit runs,
// out-of-range radix writes), then random values in phases, each phase under
// its own radix. Both channels idle at random in most phases. The radix is
// only written after every expected digit has come back.
// ----------------------------------------------------------------------------

module tb;
    import itrd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 200;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_ITEMS    = 50;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   radix_we;
    logic [RADIX_WIDTH-1:0] radix;
    logic                   in_valid;
    logic                   in_ready;
    logic [INPUT_WIDTH-1:0] value;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [CHAR_WIDTH-1:0]  digit_char;
    logic                   last;

    int mismatches;
    int pending;
    int digits_checked;
    int idle_cycles;
    int stall_pct;
    int hold;
    bit idle_on;
    int values_sent;
    int radix_writes;

    always #5 clk = ~clk;

    integer_to_radix_digits DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .radix_we   (radix_we),
        .radix      (radix),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .digit_char (digit_char),
        .last       (last)
    );

    itrd_digit_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .radix_we       (radix_we),
        .radix          (radix),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .value          (value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .digit_char     (digit_char),
        .last           (last),
        .mismatches     (mismatches),
        .pending        (pending),
        .digits_checked (digits_checked)
    );

    // receiver: short random stalls, occasionally a long one
    always @(posedge clk)
    begin
        if (hold > 0)
        begin
            hold <= hold - 1;
            out_ready <= 1'b0;
        end
        else if (stall_pct > 0 && $urandom_range(0, 99) < 2)
        begin
            hold <= $urandom_range(15, 60);
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d digits outstanding",
                     idle_cycles, pending);
            $display("FAILED: results differ");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [INPUT_WIDTH-1:0] pick_value();
        logic [INPUT_WIDTH-1:0] v;
        v = $urandom();
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = v >> $urandom_range(24, 31);
            2, 3: v = v >> $urandom_range(0, 31);
            default: ;
        endcase
        return v;
    endfunction

    task automatic send_value(input logic [INPUT_WIDTH-1:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        value <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        values_sent++;
    endtask

    // hold off the sender until every expected digit has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_radix(input logic [RADIX_WIDTH-1:0] r);
        drain();
        radix_we <= 1'b1;
        radix <= r;
        @(posedge clk);
        radix_we <= 1'b0;
        radix_writes++;
    endtask

    initial
    begin
        rst_n = 1'b0;
        radix_we = 1'b0;
        radix = RADIX_RESET;
        in_valid = 1'b0;
        value = '0;
        stall_pct = 0;
        hold = 0;
        idle_on = 1'b0;
        values_sent = 0;
        radix_writes = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset radix, back to back with no stalls
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'd9);
        send_value(32'd10);
        send_value(32'hFFFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'd1000000000);
        send_value(32'd999999999);

        idle_on = 1'b1;
        stall_pct = 30;
        set_radix(RADIX_MIN);
        send_value(32'd0);
        send_value(32'hFFFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'h5555_5555);

        set_radix(RADIX_MAX);
        send_value(32'hFEDC_BA98);
        send_value(32'h7654_3210);
        send_value(32'h0000_000F);

        // out-of-range radix values saturate; radices 3 and 7 follow
        set_radix(5'd0);
        send_value(32'd6);
        set_radix(5'd1);
        send_value(32'hAAAA_AAAA);
        set_radix(5'd17);
        send_value(32'hFFFF_FFFF);
        set_radix(5'd31);
        send_value(32'h1234_ABCD);
        set_radix(5'd3);
        send_value(32'hFFFF_FFFF);
        send_value(32'd1);
        set_radix(5'd7);
        send_value(32'd48);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case ($urandom_range(0, 9))
                0: set_radix(5'd0);
                1: set_radix(5'd1);
                2: set_radix(5'd17 + 5'($urandom_range(0, 14)));
                default: set_radix(5'($urandom_range(2, 16)));
            endcase
            idle_on = (p % 4 != 0);
            stall_pct = idle_on ? $urandom_range(10, 60) : 0;
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_value(pick_value());
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Summary: %0d values converted under %0d radix writes (saturating values included),",
                 values_sent, radix_writes);
        $display("         %0d digit characters compared.", digits_checked);
        if (mismatches == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
